// File: hw/rtl/safezone_stop_tracker_core_defines.svh
// Assertion macros for the stop tracker core.
`ifndef SAFEZONE_STOP_TRACKER_CORE_DEFINES_SVH
`define SAFEZONE_STOP_TRACKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSZ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SSZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SSZ_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SSZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/ssz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssz_pkg;

    localparam int PRICE_W = 32;
    localparam int STOP_W  = 41;
    localparam int COEF_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 2;

    localparam logic [CFG_AW-1:0] REG_DIRECTION   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_LOOKBACK    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HOLD_SPAN   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_COEFFICIENT = 2'd3;

    typedef struct packed {
        logic               first_bar;
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
    } in_t;

    typedef struct packed {
        logic signed [STOP_W-1:0] stop_price;
        logic [PRICE_W-1:0]       bar_number;
    } out_t;

endpackage
`default_nettype wire

// File: hw/rtl/ssz_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
module ssz_muldiv #(
    parameter int SUM_W = 39,
    parameter int CNT_W = 7
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [ssz_pkg::COEF_W-1:0] coef,
    input  wire logic [SUM_W-1:0]       sum_in,
    input  wire logic [CNT_W-1:0]       cnt_in,
    output logic                        done,
    output logic [SUM_W+7:0]            quot
);
    localparam int P_W = SUM_W + ssz_pkg::COEF_W;
    localparam int Q_W = P_W - 8;
    localparam int SW  = $clog2(Q_W + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    logic [1:0]                  phase_reg, phase_next;
    logic [P_W-1:0]              acc_reg, acc_next;
    logic [ssz_pkg::COEF_W-1:0]  coef_sh_reg, coef_sh_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic [Q_W-1:0]              dvd_reg, dvd_next;
    logic [SW-1:0]               step_reg, step_next;
    logic                        done_reg, done_next;

    logic [P_W-1:0] alu_a, alu_b;
    logic           alu_cin;
    logic [P_W:0]   alu_res;
    logic [CNT_W:0] rem_shift;

    // One adder serves both the shift-add multiply and the restoring divide.
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[Q_W-1]};
        if (phase_reg == P_MUL) begin
            alu_a   = {acc_reg[P_W-2:0], 1'b0};
            alu_b   = coef_sh_reg[ssz_pkg::COEF_W-1] ?
                      {{ssz_pkg::COEF_W{1'b0}}, sum_reg} : '0;
            alu_cin = 1'b0;
        end else begin
            alu_a   = {{(P_W-CNT_W-1){1'b0}}, rem_shift};
            alu_b   = ~{{(P_W-CNT_W){1'b0}}, cnt_reg};
            alu_cin = 1'b1;
        end
        alu_res = {1'b0, alu_a} + {1'b0, alu_b} + {{P_W{1'b0}}, alu_cin};
    end

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        coef_sh_next = coef_sh_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        case (phase_reg)
            P_IDLE: begin
                if (start) begin
                    acc_next     = '0;
                    coef_sh_next = coef;
                    sum_next     = sum_in;
                    cnt_next     = cnt_in;
                    step_next    = '0;
                    phase_next   = P_MUL;
                end
            end
            P_MUL: begin
                acc_next     = alu_res[P_W-1:0];
                coef_sh_next = {coef_sh_reg[ssz_pkg::COEF_W-2:0], 1'b0};
                step_next    = step_reg + SW'(1);
                if (step_reg == SW'(ssz_pkg::COEF_W - 1)) begin
                    dvd_next   = alu_res[P_W-1:8];
                    rem_next   = '0;
                    step_next  = '0;
                    phase_next = P_DIV;
                end
            end
            P_DIV: begin
                rem_next  = alu_res[P_W] ? alu_res[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                dvd_next  = {dvd_reg[Q_W-2:0], alu_res[P_W]};
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(Q_W - 1)) begin
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        acc_reg     <= acc_next;
        coef_sh_reg <= coef_sh_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        step_reg    <= step_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule
`default_nettype wire

// File: hw/rtl/safezone_stop_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "safezone_stop_tracker_core_defines.svh"
// Channel   Ports                                   Direction
// input     s_valid, s_ready, s_data (in_t)          bars in
// result    m_valid, m_ready, m_data (out_t)         stops out
// config    cfg_we, cfg_addr, cfg_wdata              register writes
// A request with a result is accepted, scans the stored bars and passes a start step; when
// any pair penetrates, the shared adder then multiplies and divides. The core then forms the
// raw stop, walks the held stops and writes the result; a bar without a result goes from
// acceptance straight to the write step.
// Reset is synchronous and active low; it resets control state only.
// A finished result waits in the output register while the next request is taken; the
// write cycle of the next result waits until the previous result has been accepted.
module safezone_stop_tracker_core #(
    parameter int MAX_LOOKBACK = 64,
    parameter int MAX_HOLD     = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ssz_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ssz_pkg::out_t                      m_data,
    input  wire logic                          cfg_we,
    input  wire logic [ssz_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [ssz_pkg::CFG_W-1:0]     cfg_wdata
);
    localparam int DEPTH = MAX_LOOKBACK + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LBW   = $clog2(MAX_LOOKBACK + 1);
    localparam int TW    = $clog2(MAX_LOOKBACK + 2);
    localparam int SUM_W = ssz_pkg::PRICE_W + LBW;
    localparam int Q_W   = SUM_W + 8;
    localparam int RAW_W = Q_W + 2;
    localparam int HW    = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;
    localparam int VW    = $clog2(MAX_HOLD + 1);
    localparam int PW    = ssz_pkg::PRICE_W;
    localparam int SW    = ssz_pkg::STOP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MSTART = 3'd2;
    localparam logic [2:0] S_MWAIT  = 3'd3;
    localparam logic [2:0] S_RAW    = 3'd4;
    localparam logic [2:0] S_HOLD   = 3'd5;
    localparam logic [2:0] S_WRITE  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        direction_reg, direction_next;
    logic [6:0]  lookback_reg, lookback_next;
    logic [8:0]  hold_span_reg, hold_span_next;
    logic [15:0] coefficient_reg, coefficient_next;

    logic [PW-1:0] hi_in_reg, hi_in_next, lo_in_reg, lo_in_next;
    logic [PW-1:0] loop_reg, loop_next, bar_count_reg, bar_count_next;
    logic          produce_reg, produce_next;
    logic [AW-1:0] bar_pos_reg, bar_pos_next, bar_ptr_reg, bar_ptr_next;
    logic [TW-1:0] total_reg, total_next, issued_reg, issued_next, elem_reg, elem_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] prior_hi_reg, prior_hi_next, prior_lo_reg, prior_lo_next;
    logic [PW-1:0] prev_hi_reg, prev_hi_next, prev_lo_reg, prev_lo_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [LBW-1:0]   cnt_reg, cnt_next;
    logic [Q_W-1:0]   pen_reg, pen_next;
    logic signed [SW-1:0] raw_reg, raw_next, adj_reg, adj_next;
    logic [HW-1:0] stop_pos_reg, stop_pos_next, stop_ptr_reg, stop_ptr_next;
    logic [VW-1:0] stop_valid_reg, stop_valid_next;
    logic [VW-1:0] hold_n_reg, hold_n_next, hold_issued_reg, hold_issued_next;
    logic          hold_pend_reg, hold_pend_next;
    logic          m_valid_reg, m_valid_next;
    ssz_pkg::out_t m_data_reg, m_data_next;

    logic [PW-1:0] high_mem [DEPTH];
    logic [PW-1:0] low_mem [DEPTH];
    logic signed [SW-1:0] stop_mem [MAX_HOLD];
    logic [PW-1:0] hi_rd_reg, lo_rd_reg;
    logic signed [SW-1:0] stop_rd_reg;

    logic          accept, write_go, bar_we, stop_we, mul_start, mul_done;
    logic [Q_W-1:0] mul_quot;
    logic [31:0]   lb32, l_eff32, hold32, hold_c32, loop_in;
    logic [PW-1:0] dmax32;
    logic [VW-1:0] hold_eff;
    logic signed [RAW_W-1:0] raw_wide;
    logic signed [SW-1:0]    raw_sat;

    ssz_muldiv #(
        .SUM_W (SUM_W),
        .CNT_W (LBW)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .coef    (coefficient_reg),
        .sum_in  (sum_reg),
        .cnt_in  (cnt_reg),
        .done    (mul_done),
        .quot    (mul_quot)
    );

    always_comb begin
        accept    = s_valid && s_ready;
        write_go  = !produce_reg || !m_valid_reg || m_ready;
        bar_we    = (state_reg == S_WRITE) && write_go;
        stop_we   = bar_we && produce_reg;
        mul_start = (state_reg == S_MSTART) && (cnt_reg != '0);

        lb32    = {25'd0, lookback_reg};
        l_eff32 = (lb32 == 32'd0) ? 32'd1 :
                  ((lb32 > 32'(MAX_LOOKBACK)) ? 32'(MAX_LOOKBACK) : lb32);
        loop_in = s_data.first_bar ? 32'd0 : bar_count_reg;
        dmax32  = ((loop_in - 32'd2) < l_eff32) ? (loop_in - 32'd2) : l_eff32;

        hold32   = {23'd0, hold_span_reg};
        hold_c32 = (hold32 > 32'(MAX_HOLD)) ? 32'(MAX_HOLD) : hold32;
        hold_eff = (hold_c32[VW-1:0] < stop_valid_reg) ? hold_c32[VW-1:0] : stop_valid_reg;

        if (direction_reg)
            raw_wide = $signed({{(RAW_W-PW){1'b0}}, prior_hi_reg})
                     + $signed({2'b00, pen_reg});
        else
            raw_wide = $signed({{(RAW_W-PW){1'b0}}, prior_lo_reg})
                     - $signed({2'b00, pen_reg});
        if (raw_wide[RAW_W-1:SW-1] != {(RAW_W-SW+1){raw_wide[RAW_W-1]}})
            raw_sat = raw_wide[RAW_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            raw_sat = raw_wide[SW-1:0];
    end

    always_comb begin
        state_next       = state_reg;
        direction_next   = direction_reg;
        lookback_next    = lookback_reg;
        hold_span_next   = hold_span_reg;
        coefficient_next = coefficient_reg;
        hi_in_next       = hi_in_reg;
        lo_in_next       = lo_in_reg;
        loop_next        = loop_reg;
        bar_count_next   = bar_count_reg;
        produce_next     = produce_reg;
        bar_pos_next     = bar_pos_reg;
        bar_ptr_next     = bar_ptr_reg;
        total_next       = total_reg;
        issued_next      = issued_reg;
        elem_next        = elem_reg;
        pend_next        = pend_reg;
        prior_hi_next    = prior_hi_reg;
        prior_lo_next    = prior_lo_reg;
        prev_hi_next     = prev_hi_reg;
        prev_lo_next     = prev_lo_reg;
        sum_next         = sum_reg;
        cnt_next         = cnt_reg;
        pen_next         = pen_reg;
        raw_next         = raw_reg;
        adj_next         = adj_reg;
        stop_pos_next    = stop_pos_reg;
        stop_ptr_next    = stop_ptr_reg;
        stop_valid_next  = stop_valid_reg;
        hold_n_next      = hold_n_reg;
        hold_issued_next = hold_issued_reg;
        hold_pend_next   = hold_pend_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        if (cfg_we) begin
            case (cfg_addr)
                ssz_pkg::REG_DIRECTION:   direction_next   = cfg_wdata[0];
                ssz_pkg::REG_LOOKBACK:    lookback_next    = cfg_wdata[6:0];
                ssz_pkg::REG_HOLD_SPAN:   hold_span_next   = cfg_wdata[8:0];
                ssz_pkg::REG_COEFFICIENT: coefficient_next = cfg_wdata;
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    hi_in_next   = s_data.bar_high;
                    lo_in_next   = s_data.bar_low;
                    loop_next    = loop_in;
                    produce_next = loop_in >= (l_eff32 + 32'd1);
                    if (s_data.first_bar)
                        stop_valid_next = '0;
                    total_next   = TW'(dmax32) + TW'(1);
                    issued_next  = '0;
                    elem_next    = '0;
                    pend_next    = 1'b0;
                    sum_next     = '0;
                    cnt_next     = '0;
                    bar_ptr_next = (bar_pos_reg == '0) ? AW'(DEPTH - 1) : bar_pos_reg - AW'(1);
                    state_next   = (loop_in >= (l_eff32 + 32'd1)) ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN: begin
                if (issued_reg != total_reg) begin
                    bar_ptr_next = (bar_ptr_reg == '0) ? AW'(DEPTH - 1) : bar_ptr_reg - AW'(1);
                    issued_next  = issued_reg + TW'(1);
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    elem_next = elem_reg + TW'(1);
                    if (elem_reg == '0) begin
                        prior_hi_next = hi_rd_reg;
                        prior_lo_next = lo_rd_reg;
                    end else if (!direction_reg && (lo_rd_reg > prev_lo_reg)) begin
                        sum_next = sum_reg + {{LBW{1'b0}}, lo_rd_reg - prev_lo_reg};
                        cnt_next = cnt_reg + LBW'(1);
                    end else if (direction_reg && (prev_hi_reg > hi_rd_reg)) begin
                        sum_next = sum_reg + {{LBW{1'b0}}, prev_hi_reg - hi_rd_reg};
                        cnt_next = cnt_reg + LBW'(1);
                    end
                    prev_hi_next = hi_rd_reg;
                    prev_lo_next = lo_rd_reg;
                    if ((elem_reg + TW'(1)) == total_reg)
                        state_next = S_MSTART;
                end
            end
            S_MSTART: begin
                if (cnt_reg == '0) begin
                    pen_next   = '0;
                    state_next = S_RAW;
                end else begin
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (mul_done) begin
                    pen_next   = mul_quot;
                    state_next = S_RAW;
                end
            end
            S_RAW: begin
                raw_next         = raw_sat;
                adj_next         = raw_sat;
                hold_n_next      = hold_eff;
                hold_issued_next = '0;
                hold_pend_next   = 1'b0;
                stop_ptr_next    = (stop_pos_reg == '0) ? HW'(MAX_HOLD - 1)
                                                        : stop_pos_reg - HW'(1);
                state_next       = S_HOLD;
            end
            S_HOLD: begin
                if (hold_issued_reg != hold_n_reg) begin
                    stop_ptr_next    = (stop_ptr_reg == '0) ? HW'(MAX_HOLD - 1)
                                                            : stop_ptr_reg - HW'(1);
                    hold_issued_next = hold_issued_reg + VW'(1);
                    hold_pend_next   = 1'b1;
                end else begin
                    hold_pend_next = 1'b0;
                end
                if (hold_pend_reg) begin
                    if (!direction_reg && (stop_rd_reg > adj_reg))
                        adj_next = stop_rd_reg;
                    else if (direction_reg && (stop_rd_reg < adj_reg))
                        adj_next = stop_rd_reg;
                end
                if ((hold_issued_reg == hold_n_reg) && !hold_pend_reg)
                    state_next = S_WRITE;
            end
            S_WRITE: begin
                if (write_go) begin
                    bar_pos_next   = (bar_pos_reg == AW'(DEPTH - 1)) ? '0 : bar_pos_reg + AW'(1);
                    bar_count_next = (loop_reg == '1) ? loop_reg : loop_reg + 32'd1;
                    if (produce_reg) begin
                        stop_pos_next = (stop_pos_reg == HW'(MAX_HOLD - 1)) ? '0
                                                                         : stop_pos_reg + HW'(1);
                        if (stop_valid_reg != VW'(MAX_HOLD))
                            stop_valid_next = stop_valid_reg + VW'(1);
                        m_valid_next           = 1'b1;
                        m_data_next.stop_price = adj_reg;
                        m_data_next.bar_number = loop_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            direction_reg   <= 1'b0;
            lookback_reg    <= 7'd10;
            hold_span_reg   <= 9'd3;
            coefficient_reg <= 16'd512;
            bar_count_reg   <= '0;
            bar_pos_reg     <= '0;
            stop_pos_reg    <= '0;
            stop_valid_reg  <= '0;
            pend_reg        <= 1'b0;
            hold_pend_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            direction_reg   <= direction_next;
            lookback_reg    <= lookback_next;
            hold_span_reg   <= hold_span_next;
            coefficient_reg <= coefficient_next;
            bar_count_reg   <= bar_count_next;
            bar_pos_reg     <= bar_pos_next;
            stop_pos_reg    <= stop_pos_next;
            stop_valid_reg  <= stop_valid_next;
            pend_reg        <= pend_next;
            hold_pend_reg   <= hold_pend_next;
            m_valid_reg     <= m_valid_next;
        end
        hi_in_reg       <= hi_in_next;
        lo_in_reg       <= lo_in_next;
        loop_reg        <= loop_next;
        produce_reg     <= produce_next;
        bar_ptr_reg     <= bar_ptr_next;
        total_reg       <= total_next;
        issued_reg      <= issued_next;
        elem_reg        <= elem_next;
        prior_hi_reg    <= prior_hi_next;
        prior_lo_reg    <= prior_lo_next;
        prev_hi_reg     <= prev_hi_next;
        prev_lo_reg     <= prev_lo_next;
        sum_reg         <= sum_next;
        cnt_reg         <= cnt_next;
        pen_reg         <= pen_next;
        raw_reg         <= raw_next;
        adj_reg         <= adj_next;
        stop_ptr_reg    <= stop_ptr_next;
        hold_n_reg      <= hold_n_next;
        hold_issued_reg <= hold_issued_next;
        m_data_reg      <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (bar_we) begin
            high_mem[bar_pos_reg] <= hi_in_reg;
            low_mem[bar_pos_reg]  <= lo_in_reg;
        end
        hi_rd_reg <= high_mem[bar_ptr_reg];
        lo_rd_reg <= low_mem[bar_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (stop_we)
            stop_mem[stop_pos_reg] <= raw_reg;
        stop_rd_reg <= stop_mem[stop_ptr_reg];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SSZ_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        (state_reg == S_WRITE) && produce_reg && write_go, m_valid)
    `SSZ_ASSERT_SAME(a_stop_count_bound, aclk, aresetn, 1'b1,
        stop_valid_reg <= VW'(MAX_HOLD))
    `SSZ_ASSERT_SAME(a_scan_bound, aclk, aresetn, state_reg == S_SCAN,
        (issued_reg <= total_reg) && (elem_reg < total_reg))
    `SSZ_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept,
        (state_reg == S_SCAN) || (state_reg == S_WRITE))

endmodule
`default_nettype wire
